[rtl/msa_pkg.sv]
// ----------------------------------------------------------------------------
// Moving average smoother package
// Shared sizes, state codes and the command and status types that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int WINDOW  = 30;
  localparam int SMP_W   = 12;
  localparam int MEAN_W  = 20;
  localparam int FRAC_W  = 8;

  localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = $clog2(WINDOW * ((1 << SMP_W) - 1) + 1);
  localparam int DVD_W   = MEAN_W + CNT_W;
  localparam int STEP_W  = $clog2(MEAN_W + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  typedef struct packed {
    logic accept;
    logic update;
    logic step;
    logic publish;
  } msa_cmd_t;

  typedef struct packed {
    logic out_busy;
  } msa_stat_t;

endpackage

[rtl/msa_if.sv]
// ----------------------------------------------------------------------------
// Moving average smoother channels
// Valid/ready channels for the sample words and the result words.
// ----------------------------------------------------------------------------
interface sample_if import msa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mean_if import msa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean;
  logic              window_full;

  modport source (output valid, output mean, output window_full, input ready);
  modport sink   (input valid, input mean, input window_full, output ready);
endinterface

[rtl/msa_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module msa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/msa_ctrl.sv]
// ----------------------------------------------------------------------------
// Moving average smoother controller
// Sequences accept, store update, the divider iterations and the hand-over.
// ----------------------------------------------------------------------------
module msa_ctrl import msa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  msa_stat_t stat,
  output msa_cmd_t  cmd
);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step_cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (step_cnt == STEP_W'(MEAN_W - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.update) begin
        step_cnt <= '0;
      end else if (cmd.step) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end
    end
  end

endmodule

[rtl/msa_dp.sv]
// ----------------------------------------------------------------------------
// Moving average smoother datapath
// Sample store, running sum, fill count, restoring divider and result register.
// ----------------------------------------------------------------------------
module msa_dp import msa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  msa_cmd_t          cmd,
  output msa_stat_t         stat,
  input  logic [SMP_W-1:0]  in_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MEAN_W-1:0] out_mean,
  output logic              out_full
);

  logic [SMP_W-1:0]  sample;
  logic [SMP_W-1:0]  old_sample;
  logic [SMP_W-1:0]  ram_rdata;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [DVD_W-1:0]  dividend;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic              q_bit;
  logic [MEAN_W-1:0] dq;
  logic              full_flag;

  msa_ram #(
    .WIDTH (SMP_W),
    .DEPTH (WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (pos),
    .wdata (sample),
    .re    (cmd.accept),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  // Until the store is full the entry being replaced has not been written since reset.
  assign old_sample = (count == CNT_W'(WINDOW)) ? ram_rdata : '0;
  assign sum_next   = sum - SUM_W'(old_sample) + SUM_W'(sample);
  assign count_next = (count == CNT_W'(WINDOW)) ? count : count + CNT_W'(1);
  assign dividend   = DVD_W'({sum_next, {FRAC_W{1'b0}}});

  assign trial = {rem, dq[MEAN_W-1]};
  assign q_bit = (trial >= {1'b0, count});

  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample <= in_sample;
    end
    if (cmd.update) begin
      sum       <= sum_next;
      count     <= count_next;
      full_flag <= (count_next == CNT_W'(WINDOW));
      pos       <= (pos == POS_W'(WINDOW - 1)) ? '0 : pos + POS_W'(1);
      rem       <= dividend[DVD_W-1:MEAN_W];
      dq        <= dividend[MEAN_W-1:0];
    end else if (cmd.step) begin
      rem <= q_bit ? CNT_W'(trial - {1'b0, count}) : CNT_W'(trial);
      dq  <= {dq[MEAN_W-2:0], q_bit};
    end
    if (cmd.publish) begin
      out_mean <= dq;
      out_full <= full_flag;
    end
    if (rst) begin
      sum       <= '0;
      count     <= '0;
      pos       <= '0;
      full_flag <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[rtl/moving_average_smoother.sv]
// ----------------------------------------------------------------------------
// Moving average smoother
// Mean of the last WINDOW or fewer 12-bit samples, unsigned with 8 fraction bits.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                        Words per item
//   samples   in         sample[11:0]                   one
//   results   out        mean[19:0], window_full        one
//
// Each sample word is accepted while the store is read, then the store,
// running sum and fill count are updated, then the one-bit-per-cycle
// restoring divider runs 20 iterations, and then the result is handed to the
// output register once that holds no stalled result. Reset (synchronous,
// active high) empties the store through the fill count and is at once
// complete. A stalled result waits in the output register while the next
// sample word is already being accepted and worked on.
// ----------------------------------------------------------------------------
module moving_average_smoother import msa_pkg::*; (
  input logic      clk,
  input logic      rst,
  sample_if.sink   samples,
  mean_if.source   results
);

  msa_cmd_t  cmd;
  msa_stat_t stat;

  // The controller owns the sequence; it also decides when a sample word may
  // enter, which is only while no other word is being worked on.
  msa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the store, the sums, the divider and the result
  // register, which parts the result side from the sample side.
  msa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_sample (samples.sample),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_mean  (results.mean),
    .out_full  (results.window_full)
  );

endmodule
